// ===== rtl/core/mrf_pkg.sv =====
// Package for the Modbus RTU request framer: request kinds, function codes,
// sequencer plans, the buffer write beat type and the CRC-16/MODBUS byte step.
// No dependencies.
`default_nettype none

package mrf_pkg;

	typedef enum logic [2:0] {
		K_RD_COILS   = 3'd0,
		K_RD_HOLDING = 3'd1,
		K_RD_INPUT   = 3'd2,
		K_WR_COIL    = 3'd3,
		K_WR_REG     = 3'd4,
		K_MULTI      = 3'd5,
		K_WORD       = 3'd6,
		K_NONE       = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		OP_SINGLE,
		OP_HDR,
		OP_WORD
	} op_t;

	localparam logic [7:0]  FC_RD_COILS   = 8'h01;
	localparam logic [7:0]  FC_RD_HOLDING = 8'h03;
	localparam logic [7:0]  FC_RD_INPUT   = 8'h04;
	localparam logic [7:0]  FC_WR_COIL    = 8'h05;
	localparam logic [7:0]  FC_WR_REG     = 8'h06;
	localparam logic [7:0]  FC_WR_MULTI   = 8'h10;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;

	typedef struct packed {
		logic       en;
		logic       last;
		logic [7:0] data;
	} buf_wr_t;

	function automatic logic [7:0] fcode(input kind_t k);
		logic [7:0] f;
		case (k)
			K_RD_COILS:   f = FC_RD_COILS;
			K_RD_HOLDING: f = FC_RD_HOLDING;
			K_RD_INPUT:   f = FC_RD_INPUT;
			K_WR_COIL:    f = FC_WR_COIL;
			K_WR_REG:     f = FC_WR_REG;
			default:      f = FC_WR_MULTI;
		endcase
		return f;
	endfunction

	// number of payload bytes a plan sends before its CRC
	function automatic logic [3:0] data_len(input op_t op);
		logic [3:0] n;
		case (op)
			OP_SINGLE: n = 4'd6;
			OP_HDR:    n = 4'd7;
			default:   n = 4'd2;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/modbus_rtu_request_framer_core.sv =====
// Top level of the Modbus RTU request framer: sequencer plus frame byte buffer.
// Depends on mrf_pkg, mrf_seq and mrf_buf.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   request  | req_valid / req_ready   | kind, slave, address, value
//   byte     | byte_valid / byte_ready | frame_byte, last
//
// A request that sends bytes holds the sequencer until its final byte is written,
// one byte into the buffer memory per cycle while the buffer is not full; the next
// request is taken in the cycle of the final byte, so frames stream at one byte per
// cycle (8 bytes for a single request, 7 for a header that opens a frame, 9 for an
// empty header, 2 or 4 for a data word). Requests that send nothing are taken at once.
// The first byte passes the buffer memory and its registered read port to the byte channel.
// Reset clears the frame state (CRC 0xFFFF, no multi frame open) and empties
// the buffer; no clearing pass is needed.
// A stalled byte channel fills the buffer, then holds the sequencer.
`default_nettype none

module modbus_rtu_request_framer_core #(
	parameter int unsigned BUF_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  slave,
	input  wire logic [15:0] address,
	input  wire logic [15:0] value,
	output logic             byte_valid,
	input  wire logic        byte_ready,
	output logic [7:0]       frame_byte,
	output logic             last
);

	// write beat from sequencer to buffer, and buffer back-pressure
	mrf_pkg::buf_wr_t wr;
	logic             full;

	// decode requests, sequence bytes, keep CRC and open-frame state
	mrf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.kind      (kind),
		.slave     (slave),
		.address   (address),
		.value     (value),
		.full      (full),
		.wr        (wr)
	);

	// buffer bytes in memory; the registered read port drives the byte channel
	mrf_buf #(
		.DEPTH (BUF_DEPTH)
	) u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.full       (full),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.frame_byte (frame_byte),
		.last       (last)
	);

endmodule

`default_nettype wire

// ===== rtl/core/mrf_buf.sv =====
// Frame byte buffer: a ring memory with a registered read port that doubles as
// the output register of the byte channel. Depends on mrf_pkg.
`default_nettype none

module mrf_buf #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mrf_pkg::buf_wr_t wr,
	output logic                 full,
	output logic                 byte_valid,
	input  wire logic            byte_ready,
	output logic [7:0]           frame_byte,
	output logic                 last
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [8:0]    mem_q [DEPTH];
	logic [8:0]    out_q;
	logic          out_valid_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          load;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (count_q == CW'(DEPTH));
	// pull the next entry whenever the output slot is empty or being taken
	assign load = (count_q != '0) && (!out_valid_q || byte_ready);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_ptr_q] <= {wr.last, wr.data};
		end
		if (load) begin
			out_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (load) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({wr.en, load})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (byte_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign byte_valid = out_valid_q;
	assign frame_byte = out_q[7:0];
	assign last       = out_q[8];

endmodule

`default_nettype wire

// ===== rtl/core/mrf_seq.sv =====
// Request sequencer: decodes a request beat into a byte plan, steps through it
// one byte a cycle while the buffer is not full, and keeps the open multi-register
// frame state and CRC. Depends on mrf_pkg.
`default_nettype none

module mrf_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire logic [2:0]       kind,
	input  wire logic [7:0]       slave,
	input  wire logic [15:0]      address,
	input  wire logic [15:0]      value,
	input  wire logic             full,
	output mrf_pkg::buf_wr_t      wr
);

	logic             busy_q;
	mrf_pkg::op_t     op_q;
	logic             tail_q;
	logic [3:0]       idx_q;
	logic [7:0]       fc_q;
	logic [7:0]       slave_q;
	logic [15:0]      addr_q;
	logic [15:0]      val_q;
	logic [15:0]      crc_q;
	logic [7:0]       words_q;
	logic             open_q;

	logic [3:0]       ndata;
	logic [3:0]       last_idx;
	logic             fire;
	logic             at_end;
	logic             is_data;
	logic             accept;
	logic [7:0]       cur;

	mrf_pkg::kind_t   k;
	logic             start;
	mrf_pkg::op_t     start_op;
	logic             start_tail;
	logic             reset_crc;
	logic [7:0]       words_n;
	logic             open_n;

	assign ndata     = mrf_pkg::data_len(op_q);
	assign last_idx  = ndata - 4'd1 + (tail_q ? 4'd2 : 4'd0);
	assign fire      = busy_q && !full;
	assign at_end    = (idx_q == last_idx);
	assign is_data   = (idx_q < ndata);
	assign req_ready = !busy_q || (fire && at_end);
	assign accept    = req_valid && req_ready;
	assign k         = mrf_pkg::kind_t'(kind);

	always_comb begin
		cur = crc_q[15:8];
		if (is_data) begin
			case (op_q)
				mrf_pkg::OP_SINGLE: begin
					case (idx_q)
						4'd0:    cur = slave_q;
						4'd1:    cur = fc_q;
						4'd2:    cur = addr_q[15:8];
						4'd3:    cur = addr_q[7:0];
						4'd4:    cur = val_q[15:8];
						default: cur = val_q[7:0];
					endcase
				end
				mrf_pkg::OP_HDR: begin
					case (idx_q)
						4'd0:    cur = slave_q;
						4'd1:    cur = fc_q;
						4'd2:    cur = addr_q[15:8];
						4'd3:    cur = addr_q[7:0];
						4'd4:    cur = 8'h00;
						4'd5:    cur = val_q[7:0];
						default: cur = {val_q[6:0], 1'b0};
					endcase
				end
				default: begin
					cur = (idx_q == 4'd0) ? val_q[15:8] : val_q[7:0];
				end
			endcase
		end else if (idx_q == ndata) begin
			cur = crc_q[7:0];
		end
	end

	assign wr.en   = fire;
	assign wr.data = cur;
	assign wr.last = tail_q && at_end;

	// decode the incoming request into a plan and the next frame state
	always_comb begin
		start      = 1'b0;
		start_op   = mrf_pkg::OP_SINGLE;
		start_tail = 1'b1;
		reset_crc  = 1'b0;
		words_n    = words_q;
		open_n     = open_q;
		if (k inside {mrf_pkg::K_RD_COILS, mrf_pkg::K_RD_HOLDING, mrf_pkg::K_RD_INPUT,
			mrf_pkg::K_WR_COIL, mrf_pkg::K_WR_REG}) begin
			start     = 1'b1;
			reset_crc = 1'b1;
			words_n   = 8'd0;
			open_n    = 1'b0;
		end else if (k == mrf_pkg::K_MULTI) begin
			start      = 1'b1;
			start_op   = mrf_pkg::OP_HDR;
			start_tail = (value[7:0] == 8'd0);
			reset_crc  = 1'b1;
			words_n    = value[7:0];
			open_n     = (value[7:0] != 8'd0);
		end else if (k == mrf_pkg::K_WORD && open_q) begin
			start      = 1'b1;
			start_op   = mrf_pkg::OP_WORD;
			start_tail = (words_q == 8'd1);
			words_n    = words_q - 8'd1;
			open_n     = (words_q != 8'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && start) begin
			op_q    <= start_op;
			tail_q  <= start_tail;
			fc_q    <= mrf_pkg::fcode(k);
			slave_q <= slave;
			addr_q  <= address;
			val_q   <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 4'd0;
			crc_q   <= mrf_pkg::CRC_INIT;
			words_q <= 8'd0;
			open_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= start;
			end else if (fire && at_end) begin
				busy_q <= 1'b0;
			end
			if (accept && start) begin
				idx_q <= 4'd0;
			end else if (fire) begin
				idx_q <= idx_q + 4'd1;
			end
			// a data word keeps running on the CRC of the open frame
			if (accept && start && reset_crc) begin
				crc_q <= mrf_pkg::CRC_INIT;
			end else if (fire && is_data) begin
				crc_q <= mrf_pkg::crc_byte(crc_q, cur);
			end
			if (accept && start) begin
				words_q <= words_n;
				open_q  <= open_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mrf_chk.sv =====
// Port-level checker for the Modbus RTU request framer, bound to the top level.
// Depends on modbus_rtu_request_framer_core.
`default_nettype none

module mrf_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       byte_valid,
	input wire logic       byte_ready,
	input wire logic [7:0] frame_byte,
	input wire logic       last
);

	// a stalled byte beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid)
		else $error("byte beat dropped while stalled");

	// a stalled byte beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> $stable(frame_byte) && $stable(last))
		else $error("byte payload changed while stalled");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !byte_valid)
		else $error("byte offered right after reset");

	// a busy sequencer means bytes are in flight, so the byte channel must offer a byte
	a_busy_output: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> ##2 byte_valid)
		else $error("sequencer busy but no byte offered");

endmodule

bind modbus_rtu_request_framer_core mrf_chk u_chk (.*);

`default_nettype wire

// ===== test/tb_modbus_rtu_request_framer_core.sv =====
// Self-checking testbench for modbus_rtu_request_framer_core: drives request beats and
// checks every frame byte against an in-bench model of the framer and its CRC-16/MODBUS.
// Depends on mrf_pkg and the framer RTL.
`default_nettype none

module tb_modbus_rtu_request_framer_core;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned REPORT_LIMIT = 10;

	// one byte beat as the framer should send it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        req_valid   = 1'b0;
	logic [2:0]  kind        = mrf_pkg::K_NONE;
	logic [7:0]  slave       = 8'h00;
	logic [15:0] address     = 16'h0000;
	logic [15:0] value       = 16'h0000;
	logic        byte_ready  = 1'b0;
	wire logic   req_ready;
	wire logic   byte_valid;
	wire logic [7:0] frame_byte;
	wire logic   last;

	// bytes the framer owes us, oldest first
	frame_beat_t pending_bytes[$];

	// model of the open write-multiple frame
	logic [15:0] frame_crc  = mrf_pkg::CRC_INIT;
	logic [7:0]  words_owed = 8'd0;
	logic        frame_open = 1'b0;

	// when set, the side sends or takes every beat back to back
	logic req_steady  = 1'b0;
	logic byte_steady = 1'b0;

	int unsigned counted_items = 0;
	int unsigned bad_beats     = 0;
	int unsigned cycle_count   = 0;

	modbus_rtu_request_framer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.kind       (kind),
		.slave      (slave),
		.address    (address),
		.value      (value),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.frame_byte (frame_byte),
		.last       (last)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------------
	// Frame model
	// ---------------------------------------------------------------------

	// Fold one byte into a CRC-16/MODBUS: reflected poly, LSB first.
	function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
			input logic [7:0] octet);
		logic [15:0] c;
		c = crc ^ {8'h00, octet};
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ mrf_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Queue one payload byte and fold it into the given CRC.
	task automatic emit_byte(input logic [7:0] octet, inout logic [15:0] crc);
		pending_bytes.push_back('{data: octet, last: 1'b0});
		crc = modbus_crc_step(crc, octet);
	endtask

	// Queue the CRC trailer: low byte first, high byte ends the frame.
	task automatic emit_crc(input logic [15:0] crc);
		pending_bytes.push_back('{data: crc[7:0], last: 1'b0});
		pending_bytes.push_back('{data: crc[15:8], last: 1'b1});
	endtask

	task automatic close_frame();
		frame_crc  = mrf_pkg::CRC_INIT;
		words_owed = 8'd0;
		frame_open = 1'b0;
	endtask

	// Work out the bytes that one accepted request beat should produce.
	task automatic predict_frame_bytes(input mrf_pkg::kind_t k, input logic [7:0] sl,
			input logic [15:0] ad, input logic [15:0] val);
		logic [15:0] crc;
		logic [7:0]  count;
		logic [7:0]  func;
		crc   = mrf_pkg::CRC_INIT;
		count = val[7:0];
		case (k)
			mrf_pkg::K_NONE: begin
			end
			mrf_pkg::K_WORD: begin
				// stray word with no frame open: drop it
				if (frame_open) begin
					emit_byte(val[15:8], frame_crc);
					emit_byte(val[7:0], frame_crc);
					words_owed = words_owed - 8'd1;
					if (words_owed == 8'd0) begin
						emit_crc(frame_crc);
						close_frame();
					end
				end
			end
			mrf_pkg::K_MULTI: begin
				// a new header abandons any open frame
				close_frame();
				emit_byte(sl, crc);
				emit_byte(mrf_pkg::FC_WR_MULTI, crc);
				emit_byte(ad[15:8], crc);
				emit_byte(ad[7:0], crc);
				emit_byte(8'h00, crc);
				emit_byte(count, crc);
				emit_byte({count[6:0], 1'b0}, crc);
				if (count == 8'd0) begin
					emit_crc(crc);
				end else begin
					frame_crc  = crc;
					words_owed = count;
					frame_open = 1'b1;
				end
			end
			default: begin
				close_frame();
				case (k)
					mrf_pkg::K_RD_COILS:   func = mrf_pkg::FC_RD_COILS;
					mrf_pkg::K_RD_HOLDING: func = mrf_pkg::FC_RD_HOLDING;
					mrf_pkg::K_RD_INPUT:   func = mrf_pkg::FC_RD_INPUT;
					mrf_pkg::K_WR_COIL:    func = mrf_pkg::FC_WR_COIL;
					default:               func = mrf_pkg::FC_WR_REG;
				endcase
				emit_byte(sl, crc);
				emit_byte(func, crc);
				emit_byte(ad[15:8], crc);
				emit_byte(ad[7:0], crc);
				emit_byte(val[15:8], crc);
				emit_byte(val[7:0], crc);
				emit_crc(crc);
			end
		endcase
	endtask

	// ---------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------

	// Send one request beat after a random gap, then predict its bytes.
	// Valid is only dropped for a gap, so back-to-back beats keep it high.
	task automatic send_request(input mrf_pkg::kind_t k, input logic [7:0] sl,
			input logic [15:0] ad, input logic [15:0] val);
		int unsigned gap;
		gap = req_steady ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		slave     <= sl;
		address   <= ad;
		value     <= val;
		do @(posedge clk); while (!req_ready);
		// ignored beats do not count toward the random budget
		if (!(k == mrf_pkg::K_NONE || (k == mrf_pkg::K_WORD && !frame_open))) begin
			counted_items++;
		end
		predict_frame_bytes(k, sl, ad, val);
	endtask

	task automatic send_random_single();
		send_request(mrf_pkg::kind_t'($urandom_range(0, 4)), 8'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// Open a multi frame for count words and send the first words of them,
	// with an occasional no-request beat mixed in.
	task automatic send_multi_frame(input int unsigned count, input int unsigned words);
		logic [15:0] header;
		header      = 16'($urandom);
		header[7:0] = 8'(count);
		send_request(mrf_pkg::K_MULTI, 8'($urandom), 16'($urandom), header);
		for (int unsigned i = 0; i < words; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_request(mrf_pkg::K_NONE, 8'($urandom), 16'($urandom),
					16'($urandom));
			end
			send_request(mrf_pkg::K_WORD, 8'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	// ---------------------------------------------------------------------
	// Byte side: random stalls, each beat checked against the oldest
	// predicted byte
	// ---------------------------------------------------------------------

	initial begin
		frame_beat_t want;
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = byte_steady ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				byte_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			byte_ready <= 1'b1;
			do @(posedge clk); while (byte_valid !== 1'b1);
			if (pending_bytes.size() == 0) begin
				bad_beats++;
				if (bad_beats <= REPORT_LIMIT) begin
					$display("unexpected beat: byte %02h last %0b", frame_byte, last);
				end
			end else begin
				want = pending_bytes.pop_front();
				if (frame_byte !== want.data || last !== want.last) begin
					bad_beats++;
					if (bad_beats <= REPORT_LIMIT) begin
						$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
							want.data, want.last, frame_byte, last);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Every single request kind, with the field extremes spread over them.
	task automatic test_single_requests();
		send_request(mrf_pkg::K_RD_COILS,   8'h00, 16'h0000, 16'h0000);
		send_request(mrf_pkg::K_RD_HOLDING, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_request(mrf_pkg::K_RD_INPUT,   8'h01, 16'h8000, 16'h0001);
		send_request(mrf_pkg::K_WR_COIL,    8'hF7, 16'h0013, 16'hFF00);
		send_request(mrf_pkg::K_WR_REG,     8'h11, 16'h0001, 16'h00FF);
		send_request(mrf_pkg::K_WR_REG,     8'hFF, 16'h0000, 16'hFFFF);
		send_request(mrf_pkg::K_RD_COILS,   8'h00, 16'hFFFF, 16'h8000);
	endtask

	// Multi frames: empty, one word, word extremes, count with high bits set.
	task automatic test_multi_frames();
		send_request(mrf_pkg::K_MULTI, 8'h0A, 16'h1234, 16'h0000);
		send_request(mrf_pkg::K_MULTI, 8'hFF, 16'hFFFF, 16'h0001);
		send_request(mrf_pkg::K_WORD,  8'h00, 16'h0000, 16'hA55A);
		send_request(mrf_pkg::K_MULTI, 8'h00, 16'h0000, 16'hFF02);
		send_request(mrf_pkg::K_WORD,  8'h00, 16'h0000, 16'h0000);
		send_request(mrf_pkg::K_WORD,  8'h00, 16'h0000, 16'hFFFF);
		// high byte of value must not leak into the count
		send_request(mrf_pkg::K_MULTI, 8'h5C, 16'hFFFF, 16'hFF00);
	endtask

	// Stray word, no request, abandoned frames, ignored fields of a word.
	task automatic test_special_cases();
		send_request(mrf_pkg::K_WORD, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_request(mrf_pkg::K_NONE, 8'hFF, 16'hFFFF, 16'hFFFF);
		// abandon by a single request
		send_request(mrf_pkg::K_MULTI, 8'h21, 16'h0100, 16'h0003);
		send_request(mrf_pkg::K_WORD,  8'h00, 16'h0000, 16'h1357);
		send_request(mrf_pkg::K_RD_HOLDING, 8'h22, 16'h0200, 16'h0004);
		// abandon by a new header, which then closes empty
		send_request(mrf_pkg::K_MULTI, 8'h31, 16'h0300, 16'h0002);
		send_request(mrf_pkg::K_WORD,  8'h00, 16'h0000, 16'h2468);
		send_request(mrf_pkg::K_MULTI, 8'h32, 16'h0400, 16'h0000);
		// slave and address of a word are don't-care
		send_request(mrf_pkg::K_MULTI, 8'h41, 16'h0500, 16'h0001);
		send_request(mrf_pkg::K_WORD,  8'hFF, 16'hFFFF, 16'hBEEF);
	endtask

	// Largest counts: byte count wraps to zero at 128 and peaks at 254 for 255. Both
	// frames are left short and abandoned; then one long frame runs to its CRC.
	task automatic test_longest_frame();
		send_multi_frame(128, 2);
		send_multi_frame(255, 2);
		send_multi_frame(40, 40);
	endtask

	// Mostly well-formed traffic with random content, plus abandoned frames
	// and noise. Steady stretches on either side come and go per sequence.
	task automatic test_random_traffic();
		int unsigned target;
		int unsigned pick;
		int unsigned count;
		target = counted_items + 120;
		while (counted_items < target) begin
			req_steady  = ($urandom_range(0, 4) == 0);
			byte_steady = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 8) begin
				send_random_single();
			end else if (pick < 15) begin
				count = $urandom_range(1, 6);
				send_multi_frame(count, count);
			end else if (pick < 17) begin
				// leave the frame short; the next request abandons it
				count = $urandom_range(2, 6);
				send_multi_frame(count, $urandom_range(0, count - 1));
			end else if (pick == 17) begin
				send_multi_frame(0, 0);
			end else begin
				send_request(mrf_pkg::kind_t'($urandom_range(6, 7)), 8'($urandom),
					16'($urandom), 16'($urandom));
			end
		end
		req_steady  = 1'b0;
		byte_steady = 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Run control
	// ---------------------------------------------------------------------

	// Bound the run; a hang or lost byte ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_modbus_rtu_request_framer_core: FAIL");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_requests();
		test_multi_frames();
		test_special_cases();
		test_longest_frame();
		test_random_traffic();

		// drop valid after the final beat, then drain the byte stream
		req_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_beats == 0) begin
			$display("tb_modbus_rtu_request_framer_core: PASS");
		end else begin
			$display("tb_modbus_rtu_request_framer_core: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
